[hw/rtl/linear_svm_sgd_trainer_assert.svh]
// Assertion macros for the linear SVM SGD trainer.
`ifndef LINEAR_SVM_SGD_TRAINER_ASSERT_SVH
`define LINEAR_SVM_SGD_TRAINER_ASSERT_SVH
`ifndef ASSERT_OFF
`define SVM_SGD_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define SVM_SGD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define SVM_SGD_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define SVM_SGD_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/svm_sgd_pkg.sv]
// Shared types, constants and functions of the linear SVM SGD trainer.
`default_nettype none
package svm_sgd_pkg;

    localparam int FEATURE_BITS = 16;
    localparam int MAX_FEATURES = 8;
    localparam int FEAT_FRAC    = 8;
    localparam int W_FRAC       = 16;
    localparam int W_BITS       = 32;
    localparam int RATE_BITS    = 16;
    localparam int PROD_W       = W_BITS + FEATURE_BITS;
    localparam int TERM_W       = PROD_W - FEAT_FRAC;
    localparam int ACC_W        = TERM_W + 4;

    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_TRAIN   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PREDICT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REGULARIZATION = 1'b1;

    localparam logic [RATE_BITS-1:0] RESET_LEARNING_RATE  = 16'd66;
    localparam logic [RATE_BITS-1:0] RESET_REGULARIZATION = 16'd655;

    localparam logic signed [W_BITS-1:0] ONE_Q16     = 32'sd65536;
    localparam logic signed [W_BITS-1:0] NEG_ONE_Q16 = -32'sd65536;

    typedef struct packed {
        logic [CMD_W-1:0]               cmd;
        logic signed [FEATURE_BITS-1:0] feature_0;
        logic signed [FEATURE_BITS-1:0] feature_1;
        logic signed [FEATURE_BITS-1:0] feature_2;
        logic signed [FEATURE_BITS-1:0] feature_3;
        logic signed [FEATURE_BITS-1:0] feature_4;
        logic signed [FEATURE_BITS-1:0] feature_5;
        logic signed [FEATURE_BITS-1:0] feature_6;
        logic signed [FEATURE_BITS-1:0] feature_7;
        logic                           label;
    } t_in_item;

    typedef struct packed {
        logic                     predicted_class;
        logic                     margin_met;
        logic signed [W_BITS-1:0] score;
    } t_out_item;

    typedef struct packed {
        logic mul_en;
        logic step_en;
        logic write_en;
        logic clear;
        logic met;
        logic label;
    } t_lane_ctrl;

    function automatic logic signed [W_BITS-1:0] sat_w(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-W_BITS:0] top_bits;
        top_bits = v[ACC_W-1:W_BITS-1];
        if ((&top_bits) || (~|top_bits)) begin
            return v[W_BITS-1:0];
        end else if (v[ACC_W-1]) begin
            return {1'b1, {(W_BITS-1){1'b0}}};
        end else begin
            return {1'b0, {(W_BITS-1){1'b1}}};
        end
    endfunction

endpackage
`default_nettype wire

[hw/rtl/svm_sgd_lane.sv]
// One feature lane: weight register, product term, decay and update step.
`default_nettype none
module svm_sgd_lane (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire svm_sgd_pkg::t_lane_ctrl                       i_ctrl,
    input  wire logic signed [svm_sgd_pkg::FEATURE_BITS-1:0]   i_feature,
    input  wire logic [svm_sgd_pkg::RATE_BITS-1:0]             i_learning_rate,
    input  wire logic [svm_sgd_pkg::RATE_BITS-1:0]             i_regularization,
    output logic signed [svm_sgd_pkg::TERM_W-1:0]              o_term
);

    localparam int W_BITS      = svm_sgd_pkg::W_BITS;
    localparam int FB          = svm_sgd_pkg::FEATURE_BITS;
    localparam int RB          = svm_sgd_pkg::RATE_BITS;
    localparam int W_FRAC      = svm_sgd_pkg::W_FRAC;
    localparam int FEAT_FRAC   = svm_sgd_pkg::FEAT_FRAC;
    localparam int PROD_W      = svm_sgd_pkg::PROD_W;
    localparam int TERM_W      = svm_sgd_pkg::TERM_W;
    localparam int ACC_W       = svm_sgd_pkg::ACC_W;
    localparam int DEC_PROD_W  = W_BITS + RB + 1;
    localparam int DECAY_W     = DEC_PROD_W - W_FRAC;
    localparam int FX_W        = FB + FEAT_FRAC;
    localparam int D_W         = DECAY_W + 1;
    localparam int STEP_PROD_W = D_W + RB + 1;
    localparam int STEP_W      = STEP_PROD_W - W_FRAC;
    localparam int NEW_W       = STEP_W + 1;

    localparam logic signed [DEC_PROD_W-1:0]  DEC_RND  = DEC_PROD_W'(1) << (W_FRAC - 1);
    localparam logic signed [STEP_PROD_W-1:0] STEP_RND = STEP_PROD_W'(1) << (W_FRAC - 1);

    logic signed [W_BITS-1:0]      r_w;
    logic signed [TERM_W-1:0]      r_term;
    logic signed [DECAY_W-1:0]     r_decay;
    logic signed [STEP_W-1:0]      r_step;

    logic signed [PROD_W-1:0]      prod;
    logic signed [PROD_W-1:0]      prod_sh;
    logic signed [RB:0]            lambda_s;
    logic signed [RB:0]            lr_s;
    logic signed [DEC_PROD_W-1:0]  decay_prod;
    logic signed [DEC_PROD_W-1:0]  decay_sh;
    logic signed [D_W-1:0]         decay_ext;
    logic signed [D_W-1:0]         fx_ext;
    logic signed [D_W-1:0]         d;
    logic signed [STEP_PROD_W-1:0] step_prod;
    logic signed [STEP_PROD_W-1:0] step_sh;
    logic signed [NEW_W-1:0]       w_new;
    logic signed [W_BITS-1:0]      w_sat;

    assign prod       = r_w * i_feature;
    assign prod_sh    = prod >>> FEAT_FRAC;
    assign lambda_s   = {1'b0, i_regularization};
    assign lr_s       = {1'b0, i_learning_rate};
    assign decay_prod = lambda_s * r_w;
    assign decay_sh   = (decay_prod + DEC_RND) >>> W_FRAC;

    assign decay_ext = {r_decay[DECAY_W-1], r_decay};
    assign fx_ext    = {{(D_W-FX_W){i_feature[FB-1]}}, i_feature, {FEAT_FRAC{1'b0}}};

    always_comb begin
        if (i_ctrl.met) begin
            d = decay_ext;
        end else if (i_ctrl.label) begin
            d = decay_ext - fx_ext;
        end else begin
            d = decay_ext + fx_ext;
        end
    end

    assign step_prod = lr_s * d;
    assign step_sh   = (step_prod + STEP_RND) >>> W_FRAC;

    assign w_new = {{(NEW_W-W_BITS){r_w[W_BITS-1]}}, r_w} - {r_step[STEP_W-1], r_step};
    assign w_sat = svm_sgd_pkg::sat_w({{(ACC_W-NEW_W){w_new[NEW_W-1]}}, w_new});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= '0;
        end else if (i_ctrl.clear) begin
            r_w <= '0;
        end else if (i_ctrl.write_en) begin
            r_w <= w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_term  <= prod_sh[TERM_W-1:0];
            r_decay <= decay_sh[DECAY_W-1:0];
        end
        if (i_ctrl.step_en) begin
            r_step <= step_sh[STEP_W-1:0];
        end
    end

    assign o_term = r_term;

endmodule
`default_nettype wire

[hw/rtl/svm_sgd_merge.sv]
// Merging stage: adds the lane terms and the bias and saturates the score.
`default_nettype none
module svm_sgd_merge #(
    parameter int NUM_FEATURES = 8
) (
    input  wire logic                                                  i_clk,
    input  wire logic                                                  i_en,
    input  wire logic [NUM_FEATURES-1:0][svm_sgd_pkg::TERM_W-1:0]      i_terms,
    input  wire logic signed [svm_sgd_pkg::W_BITS-1:0]                 i_bias,
    output logic signed [svm_sgd_pkg::W_BITS-1:0]                      o_score
);

    localparam int TERM_W = svm_sgd_pkg::TERM_W;
    localparam int ACC_W  = svm_sgd_pkg::ACC_W;
    localparam int W_BITS = svm_sgd_pkg::W_BITS;

    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] sum;

    always_comb begin
        sum = {{(ACC_W-W_BITS){i_bias[W_BITS-1]}}, i_bias};
        for (int i = 0; i < NUM_FEATURES; i++) begin
            sum = sum + {{(ACC_W-TERM_W){i_terms[i][TERM_W-1]}}, i_terms[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc <= sum;
        end
    end

    assign o_score = svm_sgd_pkg::sat_w(r_acc);

endmodule
`default_nettype wire

[hw/rtl/linear_svm_sgd_trainer.sv]
// Top level of the linear SVM trainer: control, bias, configuration and result register.
`default_nettype none
`include "linear_svm_sgd_trainer_assert.svh"
// Trains and applies a linear SVM with hinge loss by stochastic gradient descent. Each
// feature has a lane of its own holding its weight and multiplier; a merging stage sums the
// lane products with the bias. One item is worked on at a time: a train transfer goes
// through product, sum, margin and result, update step and weight write before the next
// acceptance, a predict or clear transfer through the multiply, sum and result states. A
// finished result waits in an output register, so the next item is taken while that result
// is still stalled. Configuration writes are always ready and are meant to happen while no
// item is in flight.
module linear_svm_sgd_trainer #(
    parameter int NUM_FEATURES = 8
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire logic                                       i_in_valid,
    output logic                                            o_in_stall,
    input  wire svm_sgd_pkg::t_in_item                      i_in_data,
    output logic                                            o_out_valid,
    input  wire logic                                       i_out_stall,
    output svm_sgd_pkg::t_out_item                          o_out_data,
    input  wire logic                                       i_cfg_valid,
    output logic                                            o_cfg_ready,
    input  wire logic [svm_sgd_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [svm_sgd_pkg::RATE_BITS-1:0]          i_cfg_data
);

    localparam int FB     = svm_sgd_pkg::FEATURE_BITS;
    localparam int W_BITS = svm_sgd_pkg::W_BITS;
    localparam int ACC_W  = svm_sgd_pkg::ACC_W;
    localparam int RB     = svm_sgd_pkg::RATE_BITS;
    localparam int TERM_W = svm_sgd_pkg::TERM_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_RES,
        S_STEP,
        S_WRITE
    } t_state;

    t_state                      r_state;
    t_state                      n_state;
    svm_sgd_pkg::t_in_item       r_item;
    svm_sgd_pkg::t_out_item      r_out;
    svm_sgd_pkg::t_out_item      n_out;
    logic                        r_out_valid;
    logic                        n_out_valid;
    logic                        r_met;
    logic                        n_met;
    logic signed [W_BITS-1:0]    r_bias;
    logic signed [W_BITS-1:0]    n_bias;
    logic [RB-1:0]               r_lr;
    logic [RB-1:0]               r_lambda;

    logic [svm_sgd_pkg::MAX_FEATURES-1:0][FB-1:0] feats;
    logic [NUM_FEATURES-1:0][TERM_W-1:0]          terms;
    logic signed [W_BITS-1:0]                     score;
    logic                                         met;
    logic                                         out_free;
    logic                                         accept;
    logic                                         load;
    logic signed [ACC_W-1:0]                      bias_sum;
    logic signed [ACC_W-1:0]                      bias_ext;
    logic signed [ACC_W-1:0]                      lr_ext;
    svm_sgd_pkg::t_lane_ctrl                      lane_ctrl;

    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign load        = (r_state == S_RES) && out_free;

    assign feats[0] = r_item.feature_0;
    assign feats[1] = r_item.feature_1;
    assign feats[2] = r_item.feature_2;
    assign feats[3] = r_item.feature_3;
    assign feats[4] = r_item.feature_4;
    assign feats[5] = r_item.feature_5;
    assign feats[6] = r_item.feature_6;
    assign feats[7] = r_item.feature_7;

    assign lane_ctrl.mul_en   = (r_state == S_MUL);
    assign lane_ctrl.step_en  = (r_state == S_STEP);
    assign lane_ctrl.write_en = (r_state == S_WRITE);
    assign lane_ctrl.clear    = load && (r_item.cmd == svm_sgd_pkg::CMD_CLEAR);
    assign lane_ctrl.met      = r_met;
    assign lane_ctrl.label    = r_item.label;

    for (genvar g = 0; g < NUM_FEATURES; g++) begin : g_lane
        svm_sgd_lane u_lane (
            .i_clk            (i_clk),
            .i_rst_n          (i_rst_n),
            .i_ctrl           (lane_ctrl),
            .i_feature        (feats[g]),
            .i_learning_rate  (r_lr),
            .i_regularization (r_lambda),
            .o_term           (terms[g])
        );
    end

    svm_sgd_merge #(
        .NUM_FEATURES (NUM_FEATURES)
    ) u_merge (
        .i_clk   (i_clk),
        .i_en    (r_state == S_SUM),
        .i_terms (terms),
        .i_bias  (r_bias),
        .o_score (score)
    );

    assign met = r_item.label ? (score >= svm_sgd_pkg::ONE_Q16)
                              : (score <= svm_sgd_pkg::NEG_ONE_Q16);

    assign bias_ext = {{(ACC_W-W_BITS){r_bias[W_BITS-1]}}, r_bias};
    assign lr_ext   = {{(ACC_W-RB){1'b0}}, r_lr};
    assign bias_sum = r_item.label ? (bias_ext + lr_ext) : (bias_ext - lr_ext);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_met       = r_met;
        n_bias      = r_bias;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_SUM;
            end
            S_SUM: begin
                n_state = S_RES;
            end
            S_RES: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    n_met       = met;
                    n_state     = S_IDLE;
                    case (r_item.cmd)
                        svm_sgd_pkg::CMD_TRAIN: begin
                            n_out.predicted_class = !score[W_BITS-1];
                            n_out.margin_met      = met;
                            n_out.score           = score;
                            n_state               = S_STEP;
                        end
                        svm_sgd_pkg::CMD_PREDICT: begin
                            n_out.predicted_class = !score[W_BITS-1];
                            n_out.score           = score;
                        end
                        svm_sgd_pkg::CMD_CLEAR: begin
                            n_bias = '0;
                        end
                        default: begin
                            n_out = '0;
                        end
                    endcase
                end
            end
            S_STEP: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                if (!r_met) begin
                    n_bias = svm_sgd_pkg::sat_w(bias_sum);
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_met       <= 1'b0;
            r_bias      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_met       <= n_met;
            r_bias      <= n_bias;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (accept) begin
            r_item <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr     <= svm_sgd_pkg::RESET_LEARNING_RATE;
            r_lambda <= svm_sgd_pkg::RESET_REGULARIZATION;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                svm_sgd_pkg::REG_LEARNING_RATE: begin
                    r_lr <= i_cfg_data;
                end
                svm_sgd_pkg::REG_REGULARIZATION: begin
                    r_lambda <= i_cfg_data;
                end
                default: begin
                    r_lr <= r_lr;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `SVM_SGD_ASSERT_NEXT(a_accept_starts_mul, i_clk, i_rst_n, accept, r_state == S_MUL)
    `SVM_SGD_ASSERT_IMP(a_step_only_train, i_clk, i_rst_n, r_state == S_STEP, r_item.cmd == svm_sgd_pkg::CMD_TRAIN)
    `SVM_SGD_ASSERT_IMP(a_result_from_res, i_clk, i_rst_n, $rose(o_out_valid), $past(r_state) == S_RES)

endmodule
`default_nettype wire

[test/linear_svm_sgd_trainer_checker.sv]
`timescale 1ns / 100ps
// Checker for the linear SVM trainer: tracks weights and rates, predicts each result and compares it.
module linear_svm_sgd_trainer_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  logic                                  i_in_stall,
    input  svm_sgd_pkg::t_in_item                 i_in_data,
    input  logic                                  i_out_valid,
    input  logic                                  i_out_stall,
    input  svm_sgd_pkg::t_out_item                i_out_data,
    input  logic                                  i_cfg_valid,
    input  logic                                  i_cfg_ready,
    input  logic [svm_sgd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [svm_sgd_pkg::RATE_BITS-1:0]     i_cfg_data,
    output int                                    o_fail_count,
    output int                                    o_outstanding
);

    localparam int W_BITS       = svm_sgd_pkg::W_BITS;
    localparam int FEATURE_BITS = svm_sgd_pkg::FEATURE_BITS;
    localparam int MAX_FEATURES = svm_sgd_pkg::MAX_FEATURES;
    localparam int FEAT_FRAC    = svm_sgd_pkg::FEAT_FRAC;
    localparam int W_FRAC       = svm_sgd_pkg::W_FRAC;
    localparam int RATE_BITS    = svm_sgd_pkg::RATE_BITS;

    localparam longint S32_MAX  = 64'sh0000_0000_7fff_ffff;
    localparam longint S32_MIN  = -64'sh0000_0000_8000_0000;
    localparam longint HALF_Q16 = 64'sd32768;

    logic [RATE_BITS-1:0] step_rate;
    logic [RATE_BITS-1:0] decay_rate;
    logic signed [W_BITS-1:0] lane_weight [MAX_FEATURES];
    logic signed [W_BITS-1:0] bias_q;
    svm_sgd_pkg::t_out_item pending_scores [$];
    int fail_count = 0;
    int outstanding = 0;

    assign o_fail_count  = fail_count;
    assign o_outstanding = outstanding;

    function automatic logic signed [W_BITS-1:0] clamp32(input longint v);
        if (v > S32_MAX) begin
            return S32_MAX[W_BITS-1:0];
        end
        if (v < S32_MIN) begin
            return S32_MIN[W_BITS-1:0];
        end
        return v[W_BITS-1:0];
    endfunction

    // Clears on clear; scores train/predict with the current weights; hinge-loss update on train.
    function automatic svm_sgd_pkg::t_out_item svm_step(input svm_sgd_pkg::t_in_item item);
        svm_sgd_pkg::t_out_item res;
        logic signed [FEATURE_BITS-1:0] x [MAX_FEATURES];
        logic signed [W_BITS-1:0] s;
        longint acc;
        longint grad;
        longint step;
        longint y;
        logic met;
        int k;
        res = '0;
        x[0] = item.feature_0;
        x[1] = item.feature_1;
        x[2] = item.feature_2;
        x[3] = item.feature_3;
        x[4] = item.feature_4;
        x[5] = item.feature_5;
        x[6] = item.feature_6;
        x[7] = item.feature_7;
        y = item.label ? 64'sd1 : -64'sd1;
        if (item.cmd == svm_sgd_pkg::CMD_CLEAR) begin
            for (k = 0; k < MAX_FEATURES; k++) begin
                lane_weight[k] = '0;
            end
            bias_q = '0;
        end else if (item.cmd == svm_sgd_pkg::CMD_TRAIN ||
                     item.cmd == svm_sgd_pkg::CMD_PREDICT) begin
            acc = 0;
            for (k = 0; k < MAX_FEATURES; k++) begin
                acc += (longint'(lane_weight[k]) * longint'(x[k])) >>> FEAT_FRAC;
            end
            acc += longint'(bias_q);
            s = clamp32(acc);
            res.predicted_class = !s[W_BITS-1];
            res.score = s;
            if (item.cmd == svm_sgd_pkg::CMD_TRAIN) begin
                met = item.label ? (s >= svm_sgd_pkg::ONE_Q16)
                                 : (s <= svm_sgd_pkg::NEG_ONE_Q16);
                res.margin_met = met;
                for (k = 0; k < MAX_FEATURES; k++) begin
                    grad = (longint'(decay_rate) * longint'(lane_weight[k]) + HALF_Q16)
                        >>> W_FRAC;
                    if (!met) begin
                        grad -= y * (longint'(x[k]) <<< FEAT_FRAC);
                    end
                    step = (longint'(step_rate) * grad + HALF_Q16) >>> W_FRAC;
                    lane_weight[k] = clamp32(longint'(lane_weight[k]) - step);
                end
                if (!met) begin
                    bias_q = clamp32(longint'(bias_q) + y * longint'(step_rate));
                end
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        svm_sgd_pkg::t_out_item want;
        int k;
        if (!i_rst_n) begin
            step_rate  = svm_sgd_pkg::RESET_LEARNING_RATE;
            decay_rate = svm_sgd_pkg::RESET_REGULARIZATION;
            for (k = 0; k < MAX_FEATURES; k++) begin
                lane_weight[k] = '0;
            end
            bias_q = '0;
            pending_scores.delete();
            outstanding = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_scores.size() == 0) begin
                    $display("%0t: result transfer %h arrived with nothing pending",
                             $time, i_out_data);
                    fail_count++;
                end else begin
                    want = pending_scores.pop_front();
                    if (i_out_data.predicted_class !== want.predicted_class) begin
                        $display("%0t: predicted_class expected %0d, actual %0d",
                                 $time, want.predicted_class, i_out_data.predicted_class);
                        fail_count++;
                    end
                    if (i_out_data.margin_met !== want.margin_met) begin
                        $display("%0t: margin_met expected %0d, actual %0d",
                                 $time, want.margin_met, i_out_data.margin_met);
                        fail_count++;
                    end
                    if (i_out_data.score !== want.score) begin
                        $display("%0t: score expected %0d, actual %0d",
                                 $time, want.score, i_out_data.score);
                        fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == svm_sgd_pkg::REG_LEARNING_RATE) begin
                    step_rate = i_cfg_data;
                end else if (i_cfg_index == svm_sgd_pkg::REG_REGULARIZATION) begin
                    decay_rate = i_cfg_data;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pending_scores.push_back(svm_step(i_in_data));
            end
            outstanding = pending_scores.size();
        end
    end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// Testbench top for the linear SVM trainer: clock, reset, stimulus, rate phases and verdict.
module tb;

    localparam int CMD_W        = svm_sgd_pkg::CMD_W;
    localparam int CFG_IDX_W    = svm_sgd_pkg::CFG_IDX_W;
    localparam int RATE_BITS    = svm_sgd_pkg::RATE_BITS;
    localparam int FEATURE_BITS = svm_sgd_pkg::FEATURE_BITS;
    localparam int MAX_FEATURES = svm_sgd_pkg::MAX_FEATURES;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 3000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    svm_sgd_pkg::t_in_item  in_data = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    svm_sgd_pkg::t_out_item out_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = svm_sgd_pkg::REG_LEARNING_RATE;
    logic [RATE_BITS-1:0]   cfg_data = '0;
    logic [RATE_BITS-1:0]   rate_pick;
    logic [RATE_BITS-1:0]   decay_pick;
    int                     send_idle_pct = 28;
    int                     recv_idle_pct = 74;
    int                     fail_count;
    int                     outstanding;
    int                     quiet_cycles = 0;

    linear_svm_sgd_trainer u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    linear_svm_sgd_trainer_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_data),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("linear_svm_sgd_trainer: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic svm_sgd_pkg::t_in_item make_item(input logic [CMD_W-1:0] op,
                                                        input logic [8*FEATURE_BITS-1:0] feats,
                                                        input logic lbl);
        svm_sgd_pkg::t_in_item item;
        item.cmd       = op;
        item.feature_0 = feats[0*FEATURE_BITS +: FEATURE_BITS];
        item.feature_1 = feats[1*FEATURE_BITS +: FEATURE_BITS];
        item.feature_2 = feats[2*FEATURE_BITS +: FEATURE_BITS];
        item.feature_3 = feats[3*FEATURE_BITS +: FEATURE_BITS];
        item.feature_4 = feats[4*FEATURE_BITS +: FEATURE_BITS];
        item.feature_5 = feats[5*FEATURE_BITS +: FEATURE_BITS];
        item.feature_6 = feats[6*FEATURE_BITS +: FEATURE_BITS];
        item.feature_7 = feats[7*FEATURE_BITS +: FEATURE_BITS];
        item.label     = lbl;
        return item;
    endfunction

    // Labels mostly follow the sign of feature 0 so that training converges and margins get met.
    function automatic svm_sgd_pkg::t_in_item random_item();
        logic [8*FEATURE_BITS-1:0] feats;
        logic [FEATURE_BITS-1:0]   val;
        logic [CMD_W-1:0]          op;
        logic                      lbl;
        int                        roll;
        int                        style;
        int                        k;
        roll = $urandom_range(99);
        if (roll < 63) begin
            op = svm_sgd_pkg::CMD_TRAIN;
        end else if (roll < 93) begin
            op = svm_sgd_pkg::CMD_PREDICT;
        end else if (roll < 97) begin
            op = svm_sgd_pkg::CMD_CLEAR;
        end else begin
            op = CMD_UNUSED;
        end
        style = $urandom_range(99);
        for (k = 0; k < MAX_FEATURES; k++) begin
            if (style < 50) begin
                val = FEATURE_BITS'($urandom);
            end else if (style < 85) begin
                val = FEATURE_BITS'($urandom_range(1023) - 512);
            end else begin
                case ($urandom_range(3))
                    0: begin
                        val = 16'h7fff;
                    end
                    1: begin
                        val = 16'h8000;
                    end
                    2: begin
                        val = 16'h0000;
                    end
                    default: begin
                        val = 16'hffff;
                    end
                endcase
            end
            feats[k*FEATURE_BITS +: FEATURE_BITS] = val;
        end
        if ($urandom_range(99) < 80) begin
            lbl = !feats[FEATURE_BITS-1];
        end else begin
            lbl = 1'($urandom_range(1));
        end
        return make_item(op, feats, lbl);
    endfunction

    task automatic push_item(input svm_sgd_pkg::t_in_item item);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (outstanding != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_rates(input logic [RATE_BITS-1:0] lr, input logic [RATE_BITS-1:0] lam);
        cfg_valid <= 1'b1;
        cfg_index <= svm_sgd_pkg::REG_LEARNING_RATE;
        cfg_data  <= lr;
        @(posedge clk);
        while (!cfg_ready) begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_index <= svm_sgd_pkg::REG_REGULARIZATION;
        cfg_data  <= lam;
        @(posedge clk);
        while (!cfg_ready) begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int count);
        int n;
        for (n = 0; n < count; n++) begin
            push_item(random_item());
            if ($urandom_range(199) == 0) begin
                wait_drained();
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        push_item(make_item(svm_sgd_pkg::CMD_PREDICT, '0, 1'b0));
        push_item(make_item(svm_sgd_pkg::CMD_TRAIN, {8{16'h7fff}}, 1'b1));
        push_item(make_item(svm_sgd_pkg::CMD_PREDICT, {8{16'h7fff}}, 1'b0));
        push_item(make_item(svm_sgd_pkg::CMD_TRAIN, {8{16'h8000}}, 1'b0));
        push_item(make_item(svm_sgd_pkg::CMD_TRAIN, {4{16'h7fff, 16'h8000}}, 1'b1));
        push_item(make_item(svm_sgd_pkg::CMD_TRAIN, {8{16'h7fff}}, 1'b1));
        push_item(make_item(svm_sgd_pkg::CMD_PREDICT, {8{16'h8000}}, 1'b1));
        push_item(make_item(CMD_UNUSED, {8{16'h7fff}}, 1'b1));
        push_item(make_item(svm_sgd_pkg::CMD_PREDICT, {8{16'hffff}}, 1'b0));
        push_item(make_item(svm_sgd_pkg::CMD_CLEAR, {8{16'h7fff}}, 1'b1));
        push_item(make_item(svm_sgd_pkg::CMD_PREDICT, {8{16'h0100}}, 1'b1));
        push_item(make_item(svm_sgd_pkg::CMD_TRAIN, {8{16'h0100}}, 1'b0));
        push_item(make_item(svm_sgd_pkg::CMD_TRAIN, {8{16'h0001}}, 1'b1));
        push_item(make_item(svm_sgd_pkg::CMD_TRAIN, '0, 1'b0));
        push_item(make_item(svm_sgd_pkg::CMD_TRAIN, '0, 1'b1));
        push_item(make_item(CMD_UNUSED, {8{16'h8000}}, 1'b0));
        push_item(make_item(svm_sgd_pkg::CMD_PREDICT, {8{16'h0100}}, 1'b0));
        run_random(400);
        wait_drained();

        write_rates(16'hffff, 16'h0000);
        push_item(make_item(svm_sgd_pkg::CMD_CLEAR, '0, 1'b0));
        push_item(make_item(svm_sgd_pkg::CMD_TRAIN, {8{16'h7fff}}, 1'b1));
        push_item(make_item(svm_sgd_pkg::CMD_TRAIN, {8{16'h7fff}}, 1'b1));
        push_item(make_item(svm_sgd_pkg::CMD_PREDICT, {8{16'h7fff}}, 1'b1));
        push_item(make_item(svm_sgd_pkg::CMD_PREDICT, {8{16'h8000}}, 1'b0));
        push_item(make_item(svm_sgd_pkg::CMD_TRAIN, {8{16'h8000}}, 1'b1));
        run_random(150);
        wait_drained();

        send_idle_pct = 74;
        recv_idle_pct = 28;
        write_rates(16'h0000, 16'hffff);
        run_random(300);
        wait_drained();

        rate_pick  = RATE_BITS'($urandom);
        decay_pick = RATE_BITS'($urandom_range(2000));
        write_rates(rate_pick, decay_pick);
        run_random(250);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        rate_pick  = RATE_BITS'($urandom_range(8000, 200));
        decay_pick = RATE_BITS'($urandom_range(1000));
        write_rates(rate_pick, decay_pick);
        run_random(500);
        wait_drained();

        if (fail_count == 0 && outstanding == 0) begin
            $display("linear_svm_sgd_trainer: match");
        end else begin
            $display("linear_svm_sgd_trainer: mismatch");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/svm_sgd_pkg.sv
hw/rtl/svm_sgd_lane.sv
hw/rtl/svm_sgd_merge.sv
hw/rtl/linear_svm_sgd_trainer.sv
test/linear_svm_sgd_trainer_checker.sv
test/tb.sv
